// ===== rtl/tspd_pkg.sv =====
package tspd_pkg;

   localparam logic [7:0] SYNC_VALUE = 8'h47;

   localparam int RUN_W      = 4;
   localparam int LIMIT_W    = 16;
   localparam int HITS_W     = 4;
   localparam int CSR_DATA_W = 16;

   localparam logic [RUN_W-1:0]   RUN_MAX           = 4'd15;
   localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RESET = 16'd6528;
   localparam logic [HITS_W-1:0]  SYNC_HITS_RESET   = 4'd15;

   typedef enum logic [0:0] {
      CSR_PROBE_LIMIT = 1'b0,
      CSR_SYNC_HITS   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SIZE_NONE   = 2'd0,
      SIZE_CODE_A = 2'd1,
      SIZE_CODE_B = 2'd2,
      SIZE_CODE_C = 2'd3
   } size_code_type;

   // Controls shared by the three run trackers.
   typedef struct packed {
      logic             accept;   // an item is taken at the input
      logic             restart;  // that item starts a new stream
      logic             active;   // that item lies inside the probe window
      logic             load2;    // the first stage moves into the second
      logic             clear;    // a restart item moves into the second stage
      logic             write;    // the second stage retires an active item
      logic             is_sync;  // the second stage item is a sync byte
      logic [RUN_W-1:0] need;     // run length that counts as a hit
   } track_ctl_type;

endpackage

// ===== rtl/tspd_run_track.sv =====
module tspd_run_track
   import tspd_pkg::*;
#(
   parameter int SIZE = 188
) (
   input  logic          clock,
   input  logic          reset,
   input  track_ctl_type ctl,
   output logic          hit
);

   localparam int            AW   = $clog2(SIZE);
   localparam logic [AW-1:0] LAST = AW'(SIZE - 1);

   logic [AW-1:0]    phase_ff;
   logic [AW-1:0]    phase_in;
   logic [AW-1:0]    start_phase;
   logic [AW-1:0]    ph1_ff;
   logic [AW-1:0]    ph2_ff;
   logic [RUN_W-1:0] runs_mem [SIZE];
   logic [RUN_W-1:0] rd_ff;
   logic             rdv_ff;
   logic [SIZE-1:0]  valid_ff;
   logic [RUN_W-1:0] old_run;
   logic [RUN_W-1:0] new_run;

   always_comb begin
      start_phase = ctl.restart ? '0 : phase_ff;
      phase_in    = phase_ff;
      if (ctl.accept) begin
         if (!ctl.active) begin
            phase_in = start_phase;
         end else if (start_phase == LAST) begin
            phase_in = '0;
         end else begin
            phase_in = start_phase + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.accept) begin
         ph1_ff <= start_phase;
      end
   end

   // The read of the item about to enter the second stage never collides with
   // the write of the item leaving it: active neighbors sit on adjacent phases,
   // and a restart item ignores what it reads.
   always_ff @(posedge clock) begin
      if (ctl.load2) begin
         ph2_ff <= ph1_ff;
         rd_ff  <= runs_mem[ph1_ff];
         rdv_ff <= valid_ff[ph1_ff] && !ctl.clear;
      end
      if (ctl.write) begin
         runs_mem[ph2_ff] <= new_run;
      end
   end

   // Clearing wins over the write of the older item retiring in the same cycle.
   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         valid_ff <= '0;
      end else if (ctl.write) begin
         valid_ff[ph2_ff] <= 1'b1;
      end
   end

   always_comb begin
      old_run = rdv_ff ? rd_ff : '0;
      if (!ctl.is_sync) begin
         new_run = '0;
      end else if (old_run == RUN_MAX) begin
         new_run = RUN_MAX;
      end else begin
         new_run = old_run + 1'b1;
      end
      hit = new_run >= ctl.need;
   end

endmodule

// ===== rtl/ts_sync_pattern_detector_core.sv =====
// Transport stream sync detector.
// The req_ channel takes one stream byte per item, with req_first_byte marking
// the first byte of a new stream; that item clears every run counter and the
// detection result before it is counted as position zero.
// The rsp_ channel returns one item per input item: rsp_detected and
// rsp_packet_size_code as they stand after that byte.
// The csr_ port writes probe_limit (index 0) and sync_hits_needed (index 1);
// write only while no item is in flight.
// A result is valid once its byte passes the first stage, the second stage
// and the output register. Throughput is one byte per cycle while the receiver
// does not stall, set by the read-modify-write of one run counter memory per
// packet size: read as the byte enters the second stage, write as it leaves.
// Reset restores the register defaults and clears the counters at once
// through per-entry valid bits; no clearing pass is needed.
// When the receiver stalls, the three stages keep filling until the first one
// is occupied, and only then is req_stall raised; nothing is lost or repeated.
module ts_sync_pattern_detector_core
   import tspd_pkg::*;
#(
   parameter int SIZE_A = 188,
   parameter int SIZE_B = 192,
   parameter int SIZE_C = 204
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_detected,
   output logic [1:0]            rsp_packet_size_code,
   input  logic                  csr_write_enable,
   input  logic [0:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [LIMIT_W-1:0] probe_limit_ff;
   logic [HITS_W-1:0]  sync_hits_ff;
   logic [LIMIT_W-1:0] pos_ff;
   logic [LIMIT_W-1:0] pos_in;
   logic [LIMIT_W-1:0] start_pos;
   logic               accept;
   logic               active_front;
   logic               en1, en2, en3;
   logic               load2, load3;

   logic v1_ff, restart1_ff, active1_ff, sync1_ff;
   logic v2_ff, restart2_ff, active2_ff, sync2_ff;
   logic rsp_valid_ff, found_ff;
   size_code_type size_ff;
   logic found_in;
   size_code_type size_in;

   track_ctl_type ctl;
   logic          hit_a, hit_b, hit_c;
   size_code_type best;
   logic [8:0]    best_size;

   always_ff @(posedge clock) begin
      if (reset) begin
         probe_limit_ff <= PROBE_LIMIT_RESET;
         sync_hits_ff   <= SYNC_HITS_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_PROBE_LIMIT: probe_limit_ff <= csr_write_data[LIMIT_W-1:0];
            CSR_SYNC_HITS:   sync_hits_ff   <= csr_write_data[HITS_W-1:0];
            default:         probe_limit_ff <= probe_limit_ff;
         endcase
      end
   end

   assign en3       = !rsp_valid_ff || !rsp_stall;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign load2     = v1_ff && en2;
   assign load3     = v2_ff && en3;
   assign req_stall = !en1;
   assign accept    = req_valid && en1;

   // The position stops at the limit, so it never wraps.
   always_comb begin
      start_pos    = req_first_byte ? '0 : pos_ff;
      active_front = start_pos < probe_limit_ff;
      pos_in       = pos_ff;
      if (accept) begin
         pos_in = active_front ? start_pos + 1'b1 : start_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         size_ff      <= SIZE_NONE;
      end else begin
         pos_ff <= pos_in;
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            rsp_valid_ff <= v2_ff;
         end
         if (load3) begin
            found_ff <= found_in;
            size_ff  <= size_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         restart1_ff <= req_first_byte;
         active1_ff  <= active_front;
         sync1_ff    <= req_data_byte == SYNC_VALUE;
      end
      if (load2) begin
         restart2_ff <= restart1_ff;
         active2_ff  <= active1_ff;
         sync2_ff    <= sync1_ff;
      end
   end

   always_comb begin
      ctl.accept  = accept;
      ctl.restart = req_first_byte;
      ctl.active  = active_front;
      ctl.load2   = load2;
      ctl.clear   = load2 && restart1_ff;
      ctl.write   = load3 && active2_ff;
      ctl.is_sync = sync2_ff;
      ctl.need    = (sync_hits_ff == '0) ? RUN_W'(1) : sync_hits_ff;
   end

   tspd_run_track #(.SIZE(SIZE_A)) u_track_a (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .hit   (hit_a)
   );

   tspd_run_track #(.SIZE(SIZE_B)) u_track_b (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .hit   (hit_b)
   );

   tspd_run_track #(.SIZE(SIZE_C)) u_track_c (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .hit   (hit_c)
   );

   // Among sizes that hit on the same byte the smallest one wins, and among
   // equal sizes the earlier one.
   always_comb begin
      best      = SIZE_NONE;
      best_size = '1;
      if (hit_a && 9'(SIZE_A) < best_size) begin
         best      = SIZE_CODE_A;
         best_size = 9'(SIZE_A);
      end
      if (hit_b && 9'(SIZE_B) < best_size) begin
         best      = SIZE_CODE_B;
         best_size = 9'(SIZE_B);
      end
      if (hit_c && 9'(SIZE_C) < best_size) begin
         best = SIZE_CODE_C;
      end
      found_in = restart2_ff ? 1'b0 : found_ff;
      size_in  = restart2_ff ? SIZE_NONE : size_ff;
      if (!found_in && active2_ff && best != SIZE_NONE) begin
         found_in = 1'b1;
         size_in  = best;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_detected         = found_ff;
   assign rsp_packet_size_code = size_ff;

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted item did not reach the first stage");

   a_found_sticky: assert property (@(posedge clock) disable iff (reset)
      (load3 && !restart2_ff && found_ff) |=> (found_ff && $stable(size_ff)))
      else $error("detection changed without a restart");

   a_inactive_quiet: assert property (@(posedge clock) disable iff (reset)
      (load3 && !restart2_ff && !active2_ff) |=> ($stable(found_ff) && $stable(size_ff)))
      else $error("byte past the probe limit changed the result");

   a_size_matches: assert property (@(posedge clock) disable iff (reset)
      found_ff == (size_ff != SIZE_NONE))
      else $error("detection flag and packet size disagree");

endmodule

// ===== test/tb_top.sv =====
module tb_top;
   import tspd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PKT_A = 188;
   localparam int PKT_B = 192;
   localparam int PKT_C = 204;
   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD = 150;

   typedef struct packed {
      logic [7:0] data;
      logic       first;
   } byte_item_type;

   typedef struct packed {
      logic          detected;
      size_code_type code;
   } detect_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_data_byte = 8'h00;
   logic                  req_first_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_detected;
   logic [1:0]            rsp_packet_size_code;
   logic                  csr_write_enable = 1'b0;
   logic [0:0]            csr_index = 1'b0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   byte_item_type     pending_bytes [$];
   detect_result_type expected_results [$];

   // Predictor state: register copies and the per-size run counters.
   logic [LIMIT_W-1:0] limit_reg = PROBE_LIMIT_RESET;
   logic [HITS_W-1:0]  need_reg = SYNC_HITS_RESET;
   logic [15:0]        byte_pos;
   int unsigned        run_phase [3];
   logic [RUN_W-1:0]   sync_runs [3][256];
   logic               found_flag;
   size_code_type      found_code;

   int            queued_count = 0;
   int            fail_count = 0;
   int            cycle_count = 0;
   int            hold_requests = 0;
   int            hold_served = 0;
   bit            quiet_run = 1'b0;
   int            gap_left;
   int            stall_left;
   int            hold_left;
   byte_item_type next_item;
   detect_result_type want;
   logic [15:0]   lim;
   logic [3:0]    nd;
   int            k;
   int            packets;
   int            random_start;
   int            phase_start;
   bit            first_phase;

   ts_sync_pattern_detector_core #(
      .SIZE_A(PKT_A),
      .SIZE_B(PKT_B),
      .SIZE_C(PKT_C)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_first_byte(req_first_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_detected(rsp_detected),
      .rsp_packet_size_code(rsp_packet_size_code),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int pkt_length(input int idx);
      case (idx)
         0: return PKT_A;
         1: return PKT_B;
         default: return PKT_C;
      endcase
   endfunction

   function automatic void clear_stream();
      int s;
      int i;
      byte_pos = '0;
      found_flag = 1'b0;
      found_code = SIZE_NONE;
      for (s = 0; s < 3; s++) begin
         run_phase[s] = 0;
         for (i = 0; i < 256; i++) sync_runs[s][i] = '0;
      end
   endfunction

   function automatic detect_result_type sync_predict(input logic [7:0] data,
                                                      input logic first);
      detect_result_type res;
      logic [RUN_W-1:0] need;
      logic [RUN_W-1:0] run_val;
      int s;
      if (first) clear_stream();
      if (byte_pos < limit_reg) begin
         need = (need_reg == '0) ? 4'd1 : need_reg;
         for (s = 0; s < 3; s++) begin
            run_val = sync_runs[s][run_phase[s]];
            if (data != SYNC_VALUE) run_val = '0;
            else if (run_val != RUN_MAX) run_val = run_val + 1'b1;
            sync_runs[s][run_phase[s]] = run_val;
            run_phase[s] = (run_phase[s] + 1 == pkt_length(s)) ? 0 : run_phase[s] + 1;
            // Sizes ascend from A to C, so the first size to hit is the smallest one.
            if (!found_flag && run_val >= need) begin
               found_flag = 1'b1;
               case (s)
                  0: found_code = SIZE_CODE_A;
                  1: found_code = SIZE_CODE_B;
                  default: found_code = SIZE_CODE_C;
               endcase
            end
         end
         byte_pos = byte_pos + 1'b1;
      end
      res.detected = found_flag;
      res.code = found_code;
      return res;
   endfunction

   task automatic push_item(input logic [7:0] data, input logic first);
      byte_item_type item;
      item.data = data;
      item.first = first;
      pending_bytes = {pending_bytes, item};
      queued_count++;
   endtask

   // A stream of packets with a sync byte at the head of each, after an optional
   // run of junk bytes; some sync bytes are damaged at the given percentage.
   task automatic push_stream(input int idx, input int count, input bit restart,
                              input int lead, input int corrupt_pct);
      int len;
      int p;
      int i;
      logic [7:0] b;
      len = pkt_length(idx);
      for (i = 0; i < lead; i++) push_item(8'($urandom_range(0, 255)), restart && i == 0);
      for (p = 0; p < count; p++) begin
         for (i = 0; i < len; i++) begin
            if (i != 0) b = 8'($urandom_range(0, 255));
            else if ($urandom_range(0, 99) < corrupt_pct)
               b = SYNC_VALUE ^ 8'($urandom_range(1, 255));
            else b = SYNC_VALUE;
            push_item(b, restart && lead == 0 && p == 0 && i == 0);
         end
      end
   endtask

   task automatic push_noise(input int n);
      int i;
      logic [7:0] b;
      for (i = 0; i < n; i++) begin
         b = ($urandom_range(0, 3) == 0) ? SYNC_VALUE : 8'($urandom_range(0, 255));
         push_item(b, $urandom_range(0, 49) == 0);
      end
   endtask

   // Samples on the falling edge so that every update of the rising edge has settled.
   task automatic wait_idle();
      @(negedge clock);
      while (pending_bytes.size() != 0 || req_valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_config(input logic [15:0] limit, input logic [3:0] need);
      wait_idle();
      write_csr(CSR_PROBE_LIMIT, limit);
      // Bits above the register width must be dropped.
      write_csr(CSR_SYNC_HITS, {12'($urandom_range(0, 4095)), need});
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Register defaults: fifteen hits cannot be reached in a few bytes.
      push_item(8'h00, 1'b1);
      push_item(8'hFF, 1'b0);
      push_item(SYNC_VALUE, 1'b0);
      push_item(SYNC_VALUE, 1'b1);

      // A single sync byte completes a run for all three sizes at once.
      set_config(16'd4, 4'd1);
      push_item(8'h12, 1'b1);
      push_item(SYNC_VALUE, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(SYNC_VALUE, 1'b0);
      push_item(SYNC_VALUE, 1'b0);
      push_item(8'hFF, 1'b1);

      set_config(16'd4, 4'd0);
      push_item(8'h00, 1'b1);
      push_item(SYNC_VALUE, 1'b0);

      set_config(16'd0, 4'd1);
      push_item(SYNC_VALUE, 1'b1);
      push_item(8'hA5, 1'b0);

      // The limit is lowered below the current position and later raised again.
      set_config(16'd10, 4'd15);
      push_item(8'h00, 1'b1);
      push_noise(5);
      set_config(16'd3, 4'd1);
      push_item(SYNC_VALUE, 1'b0);
      push_item(SYNC_VALUE, 1'b0);
      set_config(16'hFFFF, 4'd1);
      push_item(SYNC_VALUE, 1'b0);

      random_start = queued_count;
      first_phase = 1'b1;
      while (queued_count - random_start < 1200) begin
         case ($urandom_range(0, 9))
            0: lim = 16'd0;
            1: lim = 16'hFFFF;
            2, 3: lim = 16'($urandom_range(50, 600));
            4: lim = PROBE_LIMIT_RESET;
            default: lim = 16'($urandom_range(1000, 65535));
         endcase
         case ($urandom_range(0, 9))
            0: nd = 4'd0;
            1: nd = 4'd15;
            2: nd = 4'($urandom_range(4, 14));
            default: nd = 4'($urandom_range(1, 3));
         endcase
         set_config(lim, nd);
         phase_start = queued_count;
         while (queued_count - phase_start < 200) begin
            if ($urandom_range(0, 3) != 0) begin
               k = $urandom_range(0, 2);
               packets = (nd <= 1) ? 1 : nd;
               packets = packets + $urandom_range(0, 1);
               if (packets > 3) packets = 3;
               push_stream(k, packets, $urandom_range(0, 3) != 0,
                           $urandom_range(0, 1) ? $urandom_range(0, pkt_length(k) - 1) : 0,
                           ($urandom_range(0, 2) == 0) ? 30 : 0);
            end else begin
               push_noise($urandom_range(1, 60));
            end
         end
         if (first_phase) begin
            hold_requests++;
            first_phase = 1'b0;
         end
      end

      wait_idle();
      quiet_run = 1'b1;
      push_stream(0, 1, 1'b1, 0, 0);
      push_noise(40);

      wait_idle();
      repeat (5) @(posedge clock);
      if (fail_count == 0) $display("ts_sync_pattern_detector_core test passed");
      else $display("ts_sync_pattern_detector_core test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else if (!req_valid || !req_stall) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            next_item = pending_bytes.pop_front();
            req_valid <= 1'b1;
            req_data_byte <= next_item.data;
            req_first_byte <= next_item.first;
            if (!quiet_run && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 10);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left = hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (!quiet_run && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 10) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Register writes and accepted bytes update the predictor in the order the
   // block sees them.
   always @(posedge clock) begin
      if (reset) begin
         limit_reg = PROBE_LIMIT_RESET;
         need_reg = SYNC_HITS_RESET;
         clear_stream();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PROBE_LIMIT: limit_reg = csr_write_data[LIMIT_W-1:0];
               CSR_SYNC_HITS: need_reg = csr_write_data[HITS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_results = {expected_results,
                                sync_predict(req_data_byte, req_first_byte)};
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $display("%0t: result with none expected: detected %0b size code %0d",
                     $time, rsp_detected, rsp_packet_size_code);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            if (rsp_detected !== want.detected) begin
               $display("%0t: detected expected %0b actual %0b",
                        $time, want.detected, rsp_detected);
               fail_count++;
            end
            if (rsp_packet_size_code !== want.code) begin
               $display("%0t: packet_size_code expected %0d actual %0d",
                        $time, want.code, rsp_packet_size_code);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ts_sync_pattern_detector_core test failed");
         $finish;
      end
   end

endmodule
